// ----- rtl/core/i2c_ras_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register access sequencer package
// Shared codes, field widths and the result record of the sequencer.
// ----------------------------------------------------------------------------
package i2c_ras_pkg;

  // Default width of the read length and byte counter.
  localparam int LEN_BITS_DEF = 8;

  // Stream payload widths (tdata in whole bytes, tuser in bits).
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_EVENT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;

  // ACK enable commands.
  localparam logic [1:0] ACK_LEAVE = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  // Transaction phases.
  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_IDLE       = 4'd0;
  localparam logic [PH_W-1:0] PH_START      = 4'd1;
  localparam logic [PH_W-1:0] PH_ADDR_W     = 4'd2;
  localparam logic [PH_W-1:0] PH_REG        = 4'd3;
  localparam logic [PH_W-1:0] PH_WRITE_DATA = 4'd4;
  localparam logic [PH_W-1:0] PH_RESTART    = 4'd5;
  localparam logic [PH_W-1:0] PH_ADDR_R     = 4'd6;
  localparam logic [PH_W-1:0] PH_ADDR_R_ACK = 4'd7;
  localparam logic [PH_W-1:0] PH_READ       = 4'd8;
  localparam logic [PH_W-1:0] PH_STOP       = 4'd9;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       gen_start;
    logic       gen_stop;
    logic [1:0] ack_ctrl;
    logic       clear_addr;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       done_res;
    logic       busy_res;
  } res_t;

endpackage

// ----- rtl/core/i2c_register_access_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C register access sequencer
// Steps a byte-level I2C controller through one-byte register writes and
// N-byte register reads, one controller command set per input item.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Carries
//  --------+-----------+-------------------------------------------------
//  in_*    | input     | requests and controller status events
//  out_*   | output    | controller commands, received bytes, status
//
// Every item is decided in the cycle it is accepted and its result is
// registered, so one item is taken per clock, limited only by out_tready.
// A new item is accepted while the held result is being taken.
// rst_n is synchronous and clears the phase, the busy flag and the
// output valid; the transaction operands are loaded by each request.
// A stalled result holds its value until out_tready is high.

module i2c_register_access_sequencer #(
  parameter int LEN_BITS = i2c_ras_pkg::LEN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, low bit first: dev_addr[7:0], reg_addr[7:0], write_value[7:0],
  // read_len[7:0], flag_sb, flag_addr, flag_txe, flag_btf, flag_rxne,
  // rx_data[7:0], three zero bits.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [i2c_ras_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: req_type[1:0].
  input  logic [i2c_ras_pkg::IN_TUSER_W-1:0] in_tuser,
  // out_tdata, low bit first: status[1:0], tx_valid, tx_byte[7:0],
  // gen_start, gen_stop, ack_ctrl[1:0], clear_addr, rx_valid, rx_byte[7:0],
  // rx_index[7:0], done_res, busy_res, five zero bits.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [i2c_ras_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import i2c_ras_pkg::*;

  // Unpacked input fields.
  logic [1:0] req_type;
  logic [7:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] write_value;
  logic [7:0] read_len;
  logic       flag_sb;
  logic       flag_addr;
  logic       flag_txe;
  logic       flag_btf;
  logic       flag_rxne;
  logic [7:0] rx_data;

  assign req_type    = in_tuser[1:0];
  assign dev_addr    = in_tdata[7:0];
  assign reg_addr    = in_tdata[15:8];
  assign write_value = in_tdata[23:16];
  assign read_len    = in_tdata[31:24];
  assign flag_sb     = in_tdata[32];
  assign flag_addr   = in_tdata[33];
  assign flag_txe    = in_tdata[34];
  assign flag_btf    = in_tdata[35];
  assign flag_rxne   = in_tdata[36];
  assign rx_data     = in_tdata[44:37];

  // Sequencer state.
  logic [PH_W-1:0]     phase_r, phase_nxt;
  logic                in_progress_r, in_progress_nxt;
  logic                read_flow_r, read_flow_nxt;
  logic [7:0]          device_byte_r, device_byte_nxt;
  logic [7:0]          register_byte_r, register_byte_nxt;
  logic [7:0]          pending_write_r, pending_write_nxt;
  logic [LEN_BITS-1:0] length_goal_r, length_goal_nxt;
  logic [LEN_BITS-1:0] byte_count_r, byte_count_nxt;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  res_t res_r, res_nxt;

  // Handshakes.
  logic in_acc;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Length and counter arithmetic at the counter width.
  logic [LEN_BITS+7:0] len_ext;
  logic [LEN_BITS-1:0] req_len;
  logic [LEN_BITS-1:0] count_inc;
  logic [LEN_BITS:0]   count_inc_p1;
  logic [LEN_BITS+7:0] index_ext;

  assign len_ext      = {{LEN_BITS{1'b0}}, read_len};
  assign req_len      = len_ext[LEN_BITS-1:0];
  assign count_inc    = byte_count_r + {{(LEN_BITS-1){1'b0}}, 1'b1};
  assign count_inc_p1 = {1'b0, count_inc} + {{LEN_BITS{1'b0}}, 1'b1};
  assign index_ext    = {8'b0, byte_count_r};

  // Next state and result of the item being accepted.
  always_comb begin
    phase_nxt         = phase_r;
    in_progress_nxt   = in_progress_r;
    read_flow_nxt     = read_flow_r;
    device_byte_nxt   = device_byte_r;
    register_byte_nxt = register_byte_r;
    pending_write_nxt = pending_write_r;
    length_goal_nxt   = length_goal_r;
    byte_count_nxt    = byte_count_r;
    res_nxt           = '0;

    if (req_type == REQ_WRITE || req_type == REQ_READ) begin
      // A new request: reject when busy or empty, else load and start.
      if (in_progress_r) begin
        res_nxt.status = ST_BUSY;
      end else if (req_type == REQ_READ && req_len == '0) begin
        res_nxt.status = ST_ZERO_LEN;
      end else begin
        device_byte_nxt   = dev_addr;
        register_byte_nxt = reg_addr;
        byte_count_nxt    = '0;
        if (req_type == REQ_READ) begin
          read_flow_nxt   = 1'b1;
          length_goal_nxt = req_len;
        end else begin
          read_flow_nxt     = 1'b0;
          pending_write_nxt = write_value;
          length_goal_nxt   = {{(LEN_BITS-1){1'b0}}, 1'b1};
        end
        phase_nxt         = PH_START;
        in_progress_nxt   = 1'b1;
        res_nxt.gen_start = 1'b1;
      end
    end else if (in_progress_r) begin
      // A status event: only the flag awaited in this phase counts.
      unique case (phase_r)
        PH_START: begin
          if (flag_sb) begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = device_byte_r;
            phase_nxt        = PH_ADDR_W;
          end
        end
        PH_ADDR_W: begin
          if (flag_addr) begin
            res_nxt.clear_addr = 1'b1;
            phase_nxt          = PH_REG;
          end
        end
        PH_REG: begin
          if (flag_txe) begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = register_byte_r;
            phase_nxt        = read_flow_r ? PH_RESTART : PH_WRITE_DATA;
          end
        end
        PH_WRITE_DATA: begin
          if (flag_btf) begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = pending_write_r;
            byte_count_nxt   = count_inc;
            phase_nxt        = PH_STOP;
          end
        end
        PH_RESTART: begin
          if (flag_btf) begin
            res_nxt.gen_start = 1'b1;
            phase_nxt         = PH_ADDR_R;
          end
        end
        PH_ADDR_R: begin
          if (flag_sb) begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = {device_byte_r[7:1], 1'b1};
            phase_nxt        = PH_ADDR_R_ACK;
          end
        end
        PH_ADDR_R_ACK: begin
          if (flag_addr) begin
            res_nxt.clear_addr = 1'b1;
            if (length_goal_r == {{(LEN_BITS-1){1'b0}}, 1'b1}) begin
              res_nxt.ack_ctrl = ACK_CLEAR;
              res_nxt.gen_stop = 1'b1;
            end else begin
              res_nxt.ack_ctrl = ACK_SET;
            end
            phase_nxt = PH_READ;
          end
        end
        PH_READ: begin
          if (flag_rxne) begin
            res_nxt.rx_valid = 1'b1;
            res_nxt.rx_byte  = rx_data;
            res_nxt.rx_index = index_ext[7:0];
            byte_count_nxt   = count_inc;
            // NACK and STOP ahead of the last byte.
            if (count_inc_p1 == {1'b0, length_goal_r}) begin
              res_nxt.ack_ctrl = ACK_CLEAR;
              res_nxt.gen_stop = 1'b1;
            end
            // All bytes in: restore ACK and finish.
            if (count_inc >= length_goal_r) begin
              res_nxt.ack_ctrl = ACK_SET;
              res_nxt.done_res = 1'b1;
              phase_nxt        = PH_IDLE;
              in_progress_nxt  = 1'b0;
            end
          end
        end
        PH_STOP: begin
          if (flag_btf) begin
            res_nxt.gen_stop = 1'b1;
            res_nxt.ack_ctrl = ACK_SET;
            res_nxt.done_res = 1'b1;
            phase_nxt        = PH_IDLE;
            in_progress_nxt  = 1'b0;
          end
        end
        default: begin
          phase_nxt       = PH_IDLE;
          in_progress_nxt = 1'b0;
        end
      endcase
    end

    res_nxt.busy_res = in_progress_nxt;
  end

  // Output valid follows acceptance and the downstream take.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      in_progress_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r       <= phase_nxt;
        in_progress_r <= in_progress_nxt;
      end
    end
  end

  // Transaction operands and the result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      read_flow_r     <= read_flow_nxt;
      device_byte_r   <= device_byte_nxt;
      register_byte_r <= register_byte_nxt;
      pending_write_r <= pending_write_nxt;
      length_goal_r   <= length_goal_nxt;
      byte_count_r    <= byte_count_nxt;
      res_r           <= res_nxt;
    end
  end

  // Result packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.busy_res, res_r.done_res, res_r.rx_index,
                       res_r.rx_byte, res_r.rx_valid, res_r.clear_addr,
                       res_r.ack_ctrl, res_r.gen_stop, res_r.gen_start,
                       res_r.tx_byte, res_r.tx_valid, res_r.status};

  // The busy flag and a non-idle phase always go together.
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_progress_r == (phase_r != PH_IDLE))
    else $error("busy flag and phase disagree");

  // A request taken during a transaction is reported as rejected busy.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_progress_r && (req_type == REQ_WRITE || req_type == REQ_READ)
    |=> out_tvalid && res_r.status == ST_BUSY && res_r.busy_res)
    else $error("request during a transaction was not rejected");

  // A completed transaction leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.done_res && res_r.busy_res))
    else $error("completion reported while still busy");

  // A result never loads the data register and delivers a byte together.
  a_tx_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.tx_valid && res_r.rx_valid))
    else $error("transmit and receive in one result");

endmodule
